[hw/rtl/ffha_pkg.sv]
package ffha_pkg;

  localparam int unsigned AddrWidth  = 32;
  localparam int unsigned CountWidth = 21;

  localparam logic [1:0] StatusDone    = 2'd0;
  localparam logic [1:0] StatusNull    = 2'd1;
  localparam logic [1:0] StatusNoFit   = 2'd2;
  localparam logic [1:0] StatusBadFree = 2'd3;

  localparam logic KindAlloc   = 1'b0;
  localparam logic KindRelease = 1'b1;

  typedef struct packed {
    logic                 kind;
    logic [AddrWidth-1:0] request_bytes;
    logic [AddrWidth-1:0] release_address;
  } ffha_in_t;

  typedef struct packed {
    logic [AddrWidth-1:0]  payload_address;
    logic [1:0]            status;
    logic [CountWidth-1:0] used_bytes;
    logic [CountWidth-1:0] free_bytes;
  } ffha_out_t;

endpackage

[hw/rtl/ffha_table.sv]
// Segment table memory: one write port, one registered read port.
module ffha_table #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/first_fit_heap_allocator.sv]
// First-fit heap allocator with coalescing. The segment table lives in a
// single-port-read memory walked by a small sequencer with shared adders
// and a comparator, so the work per item grows with the table: an allocate
// reads each segment scanned, plus moves entries up when a split opens a
// slot; a release reads each segment scanned, checks both neighbors, and
// moves entries down to close the slots freed by merging. A null or
// oversized request finishes without a scan. in_stall is high while an item
// is in work; a finished result waits in the output register while the next
// item is taken.
// Segment start and size are stored as byte offsets from the heap base address.
module first_fit_heap_allocator
  import ffha_pkg::*;
#(
  parameter int unsigned HEAP_BYTES   = 1048576,
  parameter int unsigned HEADER_BYTES = 12,
  parameter int unsigned ALIGN_BYTES  = 8,
  parameter int unsigned MAX_SEGMENTS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [AddrWidth-1:0] cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ffha_in_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ffha_out_t            out_data
);

  localparam int unsigned IW = $clog2(MAX_SEGMENTS);
  localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned SW = $clog2(HEAP_BYTES + 1);
  localparam int unsigned EW = SW + SW + 1;
  localparam int unsigned NW = SW + 1;
  localparam int unsigned AL = $clog2(ALIGN_BYTES);
  localparam int unsigned RW = NW + 2;
  localparam longint unsigned RECIP_L =
      ((64'd1 << (NW + AL)) + ALIGN_BYTES - 1) / ALIGN_BYTES;
  localparam logic [RW-1:0] RECIP = RW'(RECIP_L);
  localparam logic [SW-1:0] HDR   = SW'(HEADER_BYTES);
  localparam logic [SW-1:0] HEAPV = SW'(HEAP_BYTES);
  localparam logic [SW:0]   SPLIT_MIN = (SW+1)'(HEADER_BYTES + ALIGN_BYTES);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_SHIFT_RD, S_SHIFT_WR, S_ALLOC_FIN,
    S_NEXT_RD, S_NEXT_CHK, S_PREV_RD, S_PREV_CHK, S_PACK_RD, S_PACK_WR, S_DONE
  } state_t;

  state_t state;
  logic [AddrWidth-1:0] base_addr;
  logic                 kind;
  logic [SW:0]          need;      // aligned request size
  logic [AddrWidth-1:0] offset;    // release offset
  logic [IW-1:0]        idx;       // current / found entry
  logic [CW-1:0]        ptr;       // walk pointer (entry index, may equal count)
  logic [CW-1:0]        count;
  logic [SW-1:0]        in_use;
  logic [SW-1:0]        cur_start, cur_size;
  logic [SW-1:0]        acc_size;  // size being built for a merged entry
  logic                 merge_prev;
  logic                 entry0_init; // entry 0 not yet written since reset

  // Memory ports.
  logic          we;
  logic [IW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata_mem, rdata;
  logic [SW-1:0] rd_start, rd_size;
  logic          rd_free;

  ffha_table #(.DEPTH(MAX_SEGMENTS), .WIDTH(EW)) u_table (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata_mem)
  );

  logic rd_is0;
  always_ff @(posedge clk) begin
    rd_is0 <= (raddr == '0) && entry0_init;
  end
  assign rdata = rd_is0 ? {SW'(0), HEAPV - HDR, 1'b1} : rdata_mem;
  assign {rd_start, rd_size, rd_free} = rdata;

  // A request above the heap size can never fit, so only values below 2^NW
  // are rounded, by multiplying with the scaled reciprocal of the alignment.
  logic             req_big;
  logic [NW-1:0]    req_sum, req_quot, req_aligned;
  logic [NW+RW-1:0] req_prod;
  always_comb begin
    req_big     = (in_data.request_bytes > AddrWidth'(HEAP_BYTES));
    req_sum     = NW'(in_data.request_bytes) + NW'(ALIGN_BYTES - 1);
    req_prod    = (NW+RW)'(req_sum) * (NW+RW)'(RECIP);
    req_quot    = NW'(req_prod >> (NW + AL));
    req_aligned = req_quot * NW'(ALIGN_BYTES);
  end

  // Shared adders and comparator.
  logic [SW+1:0] need_hdr;
  logic [SW-1:0] head_off;
  logic          rd_pos_match;
  always_comb begin
    need_hdr     = (SW+2)'(need) + (SW+2)'(SPLIT_MIN);
    head_off     = rd_start + HDR;
    rd_pos_match = ({{(AddrWidth-SW){1'b0}}, head_off} == offset);
  end

  assign cfg_ready = (state == S_IDLE);
  assign in_stall  = (state != S_IDLE);

  logic [1:0]           res_status;
  logic [AddrWidth-1:0] res_addr;

  always_comb begin
    we = 1'b0;
    waddr = idx;
    wdata = '0;
    raddr = ptr[IW-1:0];
    unique case (state)
      S_SHIFT_RD: raddr = IW'(ptr - 1'b1);
      S_SHIFT_WR: begin
        we = 1'b1; waddr = IW'(ptr);
        if (ptr == CW'(idx) + 1'b1) begin
          // The free remainder goes into the opened slot.
          wdata = {cur_start + HDR + cur_size, acc_size, 1'b1};
        end else begin
          wdata = rdata;
        end
      end
      S_ALLOC_FIN: begin
        we = 1'b1; waddr = idx; wdata = {cur_start, cur_size, 1'b0};
      end
      S_PREV_RD: raddr = IW'(ptr - 1'b1);
      S_PREV_CHK: begin
        we = 1'b1;
        if (idx != '0 && rd_free) begin
          waddr = idx - 1'b1; wdata = {rd_start, rd_size + HDR + acc_size, 1'b1};
        end else begin
          waddr = idx; wdata = {cur_start, acc_size, 1'b1};
        end
      end
      S_PACK_WR: begin
        we = 1'b1; waddr = IW'(ptr - acc_size[CW-1:0]); wdata = rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      base_addr <= '0;
      count <= CW'(1);
      in_use <= HDR;
      out_valid <= 1'b0;
      entry0_init <= 1'b1;
      ptr <= '0;
    end else begin
      if (state == S_DONE && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (we && waddr == '0) entry0_init <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cfg_valid) base_addr <= cfg_data;
          if (in_valid && !in_stall) begin
            kind <= in_data.kind;
            need <= req_aligned;
            offset <= in_data.release_address - base_addr;
            ptr <= '0;
            res_addr <= '0;
            if (in_data.kind == KindAlloc) begin
              if (in_data.request_bytes == '0) begin
                res_status <= StatusNull; state <= S_DONE;
              end else if (req_big || req_aligned > NW'(HEAP_BYTES)) begin
                res_status <= StatusNoFit; state <= S_DONE;
              end else begin
                state <= S_SCAN_RD;
              end
            end else if (in_data.release_address == '0) begin
              res_status <= StatusNull; state <= S_DONE;
            end else begin
              state <= S_SCAN_RD;
            end
          end
        end
        S_SCAN_RD: begin
          if (ptr >= count) begin
            res_status <= (kind == KindAlloc) ? StatusNoFit : StatusBadFree;
            state <= S_DONE;
          end else begin
            state <= S_SCAN_CHK;
          end
        end
        S_SCAN_CHK: begin
          idx <= IW'(ptr);
          cur_start <= rd_start;
          if (kind == KindAlloc) begin
            if (rd_free && {1'b0, rd_size} >= need) begin
              if ((SW+2)'(rd_size) >= need_hdr && count < CW'(MAX_SEGMENTS)) begin
                // Move entries up from the top to open slot idx+1.
                cur_size <= need[SW-1:0];
                acc_size <= rd_size - need[SW-1:0] - HDR;
                ptr <= count;
                state <= S_SHIFT_RD;
              end else begin
                cur_size <= rd_size;
                state <= S_ALLOC_FIN;
              end
            end else begin
              ptr <= ptr + 1'b1; state <= S_SCAN_RD;
            end
          end else if (rd_pos_match) begin
            if (rd_free) begin
              res_status <= StatusBadFree; state <= S_DONE;
            end else begin
              in_use <= in_use - rd_size;
              acc_size <= rd_size;
              merge_prev <= 1'b0;
              ptr <= ptr + 1'b1;
              state <= S_NEXT_RD;
            end
          end else begin
            ptr <= ptr + 1'b1; state <= S_SCAN_RD;
          end
        end
        // Split: ptr walks down from count to idx+1, copying entry ptr-1.
        S_SHIFT_RD: begin
          state <= S_SHIFT_WR;
        end
        S_SHIFT_WR: begin
          if (ptr == CW'(idx) + 1'b1) begin
            count <= count + 1'b1;
            in_use <= in_use + HDR;
            state <= S_ALLOC_FIN;
          end else begin
            ptr <= ptr - 1'b1;
            state <= S_SHIFT_RD;
          end
        end
        S_ALLOC_FIN: begin
          in_use <= in_use + cur_size;
          res_addr <= base_addr + {{(AddrWidth-SW){1'b0}}, cur_start + HDR};
          res_status <= StatusDone;
          state <= S_DONE;
        end
        // Release: check next, then previous neighbor.
        S_NEXT_RD: begin
          if (ptr >= count) begin
            ptr <= CW'(idx); state <= S_PREV_RD;
          end else begin
            state <= S_NEXT_CHK;
          end
        end
        S_NEXT_CHK: begin
          if (rd_free) begin
            acc_size <= acc_size + HDR + rd_size;
            in_use <= in_use - HDR;
            count <= count - 1'b1;
            merge_prev <= 1'b1; // flag: a pack of entry ptr is owed
          end
          ptr <= CW'(idx); state <= S_PREV_RD;
          if (!rd_free) merge_prev <= 1'b0;
        end
        S_PREV_RD: begin
          // Read entry idx-1 (ptr holds idx; raddr uses ptr-1 here).
          state <= S_PREV_CHK;
        end
        S_PREV_CHK: begin
          // write happens combinationally; decide how many slots to close.
          if (idx != '0 && rd_free) begin
            in_use <= in_use - HDR;
            count <= count - 1'b1;
            // Close one slot at idx plus one more if next merged.
            ptr <= CW'(idx) + (merge_prev ? CW'(2) : CW'(1));
            acc_size <= merge_prev ? SW'(2) : SW'(1);
          end else begin
            ptr <= CW'(idx) + CW'(2);
            acc_size <= merge_prev ? SW'(1) : SW'(0);
          end
          merge_prev <= 1'b0;
          state <= S_PACK_RD;
        end
        // Pack: entry ptr moves to ptr - gap. Gap held in acc_size.
        S_PACK_RD: begin
          if (acc_size == '0 || ptr >= count + acc_size[CW-1:0]) begin
            res_status <= StatusDone; state <= S_DONE;
          end else begin
            state <= S_PACK_WR;
          end
        end
        S_PACK_WR: begin
          ptr <= ptr + 1'b1; state <= S_PACK_RD;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_data.payload_address <= res_addr;
            out_data.status <= res_status;
            out_data.used_bytes <= CountWidth'(in_use);
            out_data.free_bytes <= CountWidth'(HEAPV - in_use);
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[sim/tb_first_fit_heap_allocator.sv]
`timescale 1ns / 100ps

module tb_first_fit_heap_allocator;
  import ffha_pkg::*;

  localparam int unsigned HeapBytes   = 1048576;
  localparam int unsigned HeaderBytes = 12;
  localparam int unsigned AlignBytes  = 8;
  localparam int unsigned MaxSegments = 64;

  logic                 clk;
  logic                 rst;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [AddrWidth-1:0] cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  ffha_in_t             in_data;
  logic                 out_valid;
  logic                 out_stall;
  ffha_out_t            out_data;

  first_fit_heap_allocator i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // Shadow copy of the segment table, kept in step with accepted transactions.
  int unsigned base_q;
  int unsigned seg_start [MaxSegments];
  int unsigned seg_size [MaxSegments];
  bit          seg_free [MaxSegments];
  int unsigned seg_count;
  int unsigned used_count;

  ffha_out_t   expected_results [$];
  int unsigned error_count;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          hold_output;

  typedef struct {
    logic        kind;
    logic [31:0] request_bytes;
    logic [31:0] release_address;
    bit          typed;
    ffha_out_t   result;
  } directed_row_t;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

  function automatic void merge_next(int unsigned idx);
    seg_size[idx] += HeaderBytes + seg_size[idx+1];
    for (int unsigned k = idx + 1; k + 1 < seg_count; k++) begin
      seg_start[k] = seg_start[k+1];
      seg_size[k]  = seg_size[k+1];
      seg_free[k]  = seg_free[k+1];
    end
    seg_count--;
    used_count -= HeaderBytes;
  endfunction

  function automatic ffha_out_t heap_predict(ffha_in_t item);
    ffha_out_t   res;
    longint      aligned;
    int unsigned offset;
    int unsigned idx;
    bit          found;
    res = '0;
    found = 1'b0;
    if (item.kind == KindAlloc) begin
      aligned = ((longint'(item.request_bytes) + AlignBytes - 1) / AlignBytes) * AlignBytes;
      if (item.request_bytes == 0) begin
        res.status = StatusNull;
      end else if (aligned > HeapBytes) begin
        res.status = StatusNoFit;
      end else begin
        res.status = StatusNoFit;
        for (int unsigned i = 0; i < seg_count && !found; i++) begin
          if (seg_free[i] && seg_size[i] >= aligned) begin
            found = 1'b1;
            if (seg_size[i] >= aligned + HeaderBytes + AlignBytes &&
                seg_count < MaxSegments) begin
              for (int unsigned k = seg_count; k > i + 1; k--) begin
                seg_start[k] = seg_start[k-1];
                seg_size[k]  = seg_size[k-1];
                seg_free[k]  = seg_free[k-1];
              end
              seg_start[i+1] = seg_start[i] + HeaderBytes + aligned;
              seg_size[i+1]  = seg_size[i] - aligned - HeaderBytes;
              seg_free[i+1]  = 1'b1;
              seg_size[i]    = aligned;
              seg_count++;
              used_count += HeaderBytes;
            end
            seg_free[i] = 1'b0;
            used_count += seg_size[i];
            res.status = StatusDone;
            res.payload_address = base_q + seg_start[i] + HeaderBytes;
          end
        end
      end
    end else if (item.release_address == 0) begin
      res.status = StatusNull;
    end else begin
      offset = item.release_address - base_q;
      idx = seg_count;
      for (int unsigned i = 0; i < seg_count; i++)
        if (idx == seg_count && seg_start[i] + HeaderBytes == offset) idx = i;
      if (idx == seg_count || seg_free[idx]) begin
        res.status = StatusBadFree;
      end else begin
        seg_free[idx] = 1'b1;
        used_count -= seg_size[idx];
        if (idx + 1 < seg_count && seg_free[idx+1]) merge_next(idx);
        if (idx > 0 && seg_free[idx-1]) merge_next(idx - 1);
        res.status = StatusDone;
      end
    end
    res.used_bytes = used_count[CountWidth-1:0];
    res.free_bytes = CountWidth'(HeapBytes - used_count);
    return res;
  endfunction

  // Pushes either the typed-in result or the predicted one; the predictor
  // always runs so its table stays in step.
  task automatic send_item(ffha_in_t item, bit typed, ffha_out_t typed_result);
    ffha_out_t predicted;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      in_data  <= $bits(ffha_in_t)'({$urandom, $urandom, $urandom});
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    predicted = heap_predict(item);
    expected_results.push_back(typed ? typed_result : predicted);
  endtask

  task automatic write_base_addr(logic [31:0] value);
    in_valid <= 1'b0;
    wait (expected_results.size() == 0);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    base_q = value;
  endtask

  function automatic ffha_in_t random_item(int unsigned alloc_pct);
    ffha_in_t    item;
    int unsigned pick;
    int unsigned idx;
    item.kind            = ($urandom_range(99) < alloc_pct) ? KindAlloc : KindRelease;
    item.request_bytes   = $urandom;
    item.release_address = $urandom;
    pick = $urandom_range(99);
    if (item.kind == KindAlloc) begin
      if (pick < 70)      item.request_bytes = $urandom_range(256, 1);
      else if (pick < 88) item.request_bytes = $urandom_range(65536, 1);
      else if (pick < 92) item.request_bytes = $urandom_range(HeapBytes, HeapBytes - 64);
      else if (pick < 96) item.request_bytes = 0;
    end else begin
      idx = $urandom_range(seg_count - 1);
      // Mostly live payload addresses; the rest hit any segment, a segment plus one, null or junk.
      if (pick < 70) begin
        for (int unsigned i = 0; i < seg_count; i++)
          if (!seg_free[(idx + i) % seg_count]) begin
            idx = (idx + i) % seg_count;
            break;
          end
        item.release_address = base_q + seg_start[idx] + HeaderBytes;
      end else if (pick < 82) begin
        item.release_address = base_q + seg_start[idx] + HeaderBytes;
      end else if (pick < 88) begin
        item.release_address = base_q + seg_start[idx] + HeaderBytes + 1;
      end else if (pick < 94) begin
        item.release_address = 0;
      end
    end
    return item;
  endfunction

  // Result side: stall pattern, long hold-off, and the field checks.
  initial begin
    ffha_out_t   exp_res;
    int unsigned hold_left;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result transaction %p", out_data);
          error_count++;
        end else begin
          exp_res = expected_results.pop_front();
          if (out_data.payload_address !== exp_res.payload_address) begin
            $error("payload_address expected %h actual %h",
                   exp_res.payload_address, out_data.payload_address);
            error_count++;
          end
          if (out_data.status !== exp_res.status) begin
            $error("status expected %0d actual %0d", exp_res.status, out_data.status);
            error_count++;
          end
          if (out_data.used_bytes !== exp_res.used_bytes) begin
            $error("used_bytes expected %0d actual %0d",
                   exp_res.used_bytes, out_data.used_bytes);
            error_count++;
          end
          if (out_data.free_bytes !== exp_res.free_bytes) begin
            $error("free_bytes expected %0d actual %0d",
                   exp_res.free_bytes, out_data.free_bytes);
            error_count++;
          end
        end
      end
      if (hold_output && hold_left == 0) hold_left = 400;
      if (hold_left > 0) begin
        hold_left--;
        if (hold_left == 0) hold_output = 1'b0;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  initial begin
    directed_row_t rows [$];
    ffha_in_t      item;
    logic [31:0]   bases [4];
    int unsigned   idle_sets [4][2];
    int unsigned   alloc_bias;
    error_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_output    = 1'b0;
    base_q         = 0;
    seg_count      = 1;
    seg_start[0]   = 0;
    seg_size[0]    = HeapBytes - HeaderBytes;
    seg_free[0]    = 1'b1;
    used_count     = HeaderBytes;
    rst       <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    rows = '{
      '{KindAlloc, 0, 0, 1, '{0, StatusNull, 12, HeapBytes - 12}},
      '{KindRelease, 0, 0, 1, '{0, StatusNull, 12, HeapBytes - 12}},
      '{KindAlloc, 32'hFFFF_FFFF, 0, 1, '{0, StatusNoFit, 12, HeapBytes - 12}},
      '{KindAlloc, HeapBytes + 1, 0, 1, '{0, StatusNoFit, 12, HeapBytes - 12}},
      '{KindAlloc, HeapBytes, 0, 1, '{0, StatusNoFit, 12, HeapBytes - 12}},
      '{KindAlloc, 1, 0, 1, '{12, StatusDone, 32, HeapBytes - 32}},
      '{KindAlloc, 100, 0, 0, '0},
      '{KindAlloc, 7, 32'hFFFF_FFFF, 0, '0},
      '{KindRelease, 32'hFFFF_FFFF, 12, 0, '0},
      '{KindRelease, 0, 12, 0, '0},
      '{KindRelease, 0, 13, 0, '0},
      '{KindRelease, 0, 32'hFFFF_FFFF, 0, '0},
      '{KindRelease, 0, 32, 0, '0},
      '{KindRelease, 0, 156, 0, '0},
      '{KindAlloc, 1048564, 0, 0, '0},
      '{KindAlloc, 1048560, 0, 0, '0},
      '{KindAlloc, 8, 0, 0, '0},
      '{KindRelease, 0, 12, 0, '0},
      '{KindAlloc, 1048552, 0, 0, '0},
      '{KindRelease, 0, 12, 0, '0}
    };
    foreach (rows[r]) begin
      item.kind            = rows[r].kind;
      item.request_bytes   = rows[r].request_bytes;
      item.release_address = rows[r].release_address;
      send_item(item, rows[r].typed, rows[r].result);
    end

    bases = '{32'hFFFF_FFFF, 32'h0000_0000, $urandom, 32'hFFFF_0000};
    idle_sets = '{'{0, 0}, '{54, 0}, '{0, 54}, '{7, 7}};
    for (int p = 0; p < 4; p++) begin
      write_base_addr(bases[p]);
      send_idle_pct  = idle_sets[p][0];
      recv_stall_pct = idle_sets[p][1];
      // Allocation-heavy runs fill the table so the no-split path is reached.
      alloc_bias = (p % 2 == 0) ? 80 : 55;
      for (int n = 0; n < 160; n++) begin
        if (p == 0 && n == 40) hold_output = 1'b1;
        if (n == 100) alloc_bias = 35;
        send_item(random_item(alloc_bias), 1'b0, '0);
      end
    end
    in_valid <= 1'b0;
    wait (expected_results.size() == 0);
    repeat (50) @(posedge clk);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/ffha_pkg.sv
hw/rtl/ffha_table.sv
hw/rtl/first_fit_heap_allocator.sv
sim/tb_first_fit_heap_allocator.sv
